// ----- rtl/core/vtg_pkg.sv -----
// shared types, codes and helpers for the vector tile geometry decoder
package vtg_pkg;

  // field widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CMD_ID_W = 3;
  localparam int unsigned COUNT_W  = WORD_W - CMD_ID_W;

  // command ids
  localparam logic [CMD_ID_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_ID_W-1:0] CMD_MOVE  = 3'd1;
  localparam logic [CMD_ID_W-1:0] CMD_LINE  = 3'd2;
  localparam logic [CMD_ID_W-1:0] CMD_CLOSE = 3'd7;

  // result event codes
  localparam logic [1:0] EV_MOVE  = 2'd0;
  localparam logic [1:0] EV_LINE  = 2'd1;
  localparam logic [1:0] EV_CLOSE = 2'd2;
  localparam logic [1:0] EV_POINT = 2'd3;

  // geometry type register codes, the spare code decodes as a line string
  localparam logic [1:0] GT_POINT   = 2'd0;
  localparam logic [1:0] GT_LINE    = 2'd1;
  localparam logic [1:0] GT_POLYGON = 2'd2;
  localparam logic [1:0] GT_SPARE   = 2'd3;

  // input item
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              start_feature;
  } geom_in_t;

  // result item
  typedef struct packed {
    logic [1:0]               event_res;
    logic signed [WORD_W-1:0] coord_x;
    logic signed [WORD_W-1:0] coord_y;
  } geom_out_t;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_CMD,
    OP_CLOSE,
    OP_X,
    OP_Y
  } op_kind_t;

  typedef struct packed {
    logic              clear;
    op_kind_t          kind;
    logic              emit;
    logic [1:0]        event_res;
    logic [WORD_W-1:0] delta;
  } geom_op_t;

  // zigzag decode of a parameter word
  function automatic logic [WORD_W-1:0] unzig(input logic [WORD_W-1:0] w);
    return (w >> 1) ^ {WORD_W{w[0]}};
  endfunction

endpackage

// ----- rtl/core/vtg_queue.sv -----
// small register queue with occupancy count
module vtg_queue
  #(
    parameter type         item_t = logic,
    parameter int unsigned DEPTH  = 4
  )
  (
    input  logic  clk,
    input  logic  rst,
    input  logic  push,
    input  item_t push_data,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  empty
  );

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t              mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/vtg_front.sv -----
// front end: command parser that classifies each geometry word
module vtg_front
  import vtg_pkg::*;
  (
    input  logic       clk,
    input  logic       rst,
    input  logic [1:0] geometry_type,
    input  logic       accept,
    input  geom_in_t   item,
    output geom_op_t   op
  );

  logic [COUNT_W-1:0]  pairs_left;
  logic [CMD_ID_W-1:0] current_command;
  logic                awaiting_y;

  logic [COUNT_W-1:0]  pairs_left_next;
  logic [CMD_ID_W-1:0] current_command_next;
  logic                awaiting_y_next;

  logic [COUNT_W-1:0]  eff_pairs;
  logic [CMD_ID_W-1:0] eff_cmd;
  logic                eff_await;
  logic [CMD_ID_W-1:0] word_id;

  // feature start wipes the parser before the word is looked at
  assign eff_pairs = item.start_feature ? '0 : pairs_left;
  assign eff_cmd   = item.start_feature ? CMD_NONE : current_command;
  assign eff_await = item.start_feature ? 1'b0 : awaiting_y;
  assign word_id   = item.word[CMD_ID_W-1:0];

  // classify the word and work out the parser update
  always_comb begin
    pairs_left_next      = eff_pairs;
    current_command_next = eff_cmd;
    awaiting_y_next      = eff_await;
    op.clear             = item.start_feature;
    op.kind              = OP_CMD;
    op.emit              = 1'b0;
    op.event_res         = EV_MOVE;
    op.delta             = unzig(item.word);
    priority if (eff_pairs == '0) begin
      current_command_next = word_id;
      awaiting_y_next      = 1'b0;
      if (geometry_type == GT_POLYGON && word_id == CMD_CLOSE) begin
        pairs_left_next = '0;
        op.kind         = OP_CLOSE;
        op.emit         = 1'b1;
        op.event_res    = EV_CLOSE;
      end else begin
        pairs_left_next = item.word[WORD_W-1:CMD_ID_W];
      end
    end else if (!eff_await) begin
      op.kind         = OP_X;
      awaiting_y_next = 1'b1;
    end else begin
      op.kind         = OP_Y;
      awaiting_y_next = 1'b0;
      pairs_left_next = eff_pairs - 1'b1;
      priority if (geometry_type == GT_POINT) begin
        op.emit      = 1'b1;
        op.event_res = EV_POINT;
      end else if (eff_cmd == CMD_MOVE) begin
        op.emit      = 1'b1;
        op.event_res = EV_MOVE;
      end else if (eff_cmd == CMD_LINE) begin
        op.emit      = 1'b1;
        op.event_res = EV_LINE;
      end else begin
        op.emit      = 1'b0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_left      <= '0;
      current_command <= CMD_NONE;
      awaiting_y      <= 1'b0;
    end else if (accept) begin
      pairs_left      <= pairs_left_next;
      current_command <= current_command_next;
      awaiting_y      <= awaiting_y_next;
    end
  end

endmodule

// ----- rtl/core/vtg_back.sv -----
// back end: cursor accumulator that turns operations into results
module vtg_back
  import vtg_pkg::*;
  (
    input  logic      clk,
    input  logic      rst,
    input  logic      op_valid,
    input  geom_op_t  op,
    output logic      op_take,
    input  logic      res_full,
    output logic      res_push,
    output geom_out_t res
  );

  logic [WORD_W-1:0] cursor_x;
  logic [WORD_W-1:0] cursor_y;
  logic [WORD_W-1:0] base_x;
  logic [WORD_W-1:0] base_y;
  logic [WORD_W-1:0] cursor_x_next;
  logic [WORD_W-1:0] cursor_y_next;

  // take an operation only when its result has somewhere to go
  assign op_take  = op_valid && !res_full;
  assign res_push = op_take && op.emit;

  assign base_x = op.clear ? '0 : cursor_x;
  assign base_y = op.clear ? '0 : cursor_y;

  // delta add on the axis the operation names
  always_comb begin
    cursor_x_next = base_x;
    cursor_y_next = base_y;
    unique case (op.kind)
      OP_X:    cursor_x_next = base_x + op.delta;
      OP_Y:    cursor_y_next = base_y + op.delta;
      default: begin
        cursor_x_next = base_x;
        cursor_y_next = base_y;
      end
    endcase
  end

  assign res.event_res = op.event_res;
  assign res.coord_x   = cursor_x_next;
  assign res.coord_y   = cursor_y_next;

  // cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (op_take) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

endmodule

// ----- rtl/core/vector_tile_geometry_decoder.sv -----
// Vector tile geometry command decoder.
// Input channel: push/full with item (word, start_feature); a word is
// transferred at a clock edge with push high and full low. Result channel:
// empty/pop with result (event_res, coord_x, coord_y); the oldest result is
// shown while empty is low and transferred at an edge with pop high.
// Configuration: cfg_we/cfg_data write geometry_type (point, line, polygon);
// write it only while no words are in flight.
// A word that produces a result is written first into the operation queue
// by the parser and then into the result queue by the cursor add, and a
// full result queue can hold it between the two.
// Throughput: one word per cycle while full is low. Front and back are split
// by an OP_DEPTH operation queue, and results wait in a RES_DEPTH result
// queue, so a stalled receiver only raises full once both queues have
// filled.
// Reset (rst, synchronous): empties both queues, zeroes the cursor, returns
// the parser to expecting a command and sets geometry_type to point.
module vector_tile_geometry_decoder
  import vtg_pkg::*;
  #(
    parameter int unsigned OP_DEPTH  = 4,
    parameter int unsigned RES_DEPTH = 4
  )
  (
    input  logic      clk,
    input  logic      rst,
    input  logic      push,
    output logic      full,
    input  geom_in_t  item,
    output logic      empty,
    input  logic      pop,
    output geom_out_t result,
    input  logic      cfg_we,
    input  logic [1:0] cfg_data
  );

  logic [1:0] geometry_type;
  logic       accept;
  geom_op_t   front_op;
  geom_op_t   back_op;
  logic       op_empty;
  logic       op_take;
  logic       res_full;
  logic       res_push;
  geom_out_t  back_res;

  assign accept = push && !full;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      geometry_type <= GT_POINT;
    end else if (cfg_we) begin
      geometry_type <= cfg_data;
    end
  end

  // command parser
  vtg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .geometry_type (geometry_type),
    .accept        (accept),
    .item          (item),
    .op            (front_op)
  );

  // operation queue between parser and cursor
  vtg_queue #(
    .item_t (geom_op_t),
    .DEPTH  (OP_DEPTH)
  ) u_op_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_op),
    .full      (full),
    .pop       (op_take),
    .head      (back_op),
    .empty     (op_empty)
  );

  // cursor accumulator
  vtg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (!op_empty),
    .op       (back_op),
    .op_take  (op_take),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  // result queue
  vtg_queue #(
    .item_t (geom_out_t),
    .DEPTH  (RES_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (back_res),
    .full      (res_full),
    .pop       (pop),
    .head      (result),
    .empty     (empty)
  );

endmodule

// ----- rtl/core/vtg_checker.sv -----
// port-level checks for the geometry decoder, bound to the top level
module vtg_checker
  import vtg_pkg::*;
  (
    input logic      clk,
    input logic      rst,
    input logic      push,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input geom_out_t result
  );

  // reset leaves both channels idle
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // full only rises after a word transfer
  a_full_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an input transfer");

  // a waiting result is not withdrawn
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn before transfer");

  // a waiting result does not change
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(result))
    else $error("result changed while stalled");

endmodule

bind vector_tile_geometry_decoder vtg_checker u_vtg_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
